>>> src/assert_macros.svh
// Assertion macros for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, masked while reset is high.
`define CTC_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that also holds through reset.
`define CTC_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/ctc_pkg.sv
// Types, constants and register codes for the clock trim calibrator.
package ctc_pkg;

   localparam int TRIM_WIDTH_DEF    = 8;
   localparam int READING_WIDTH_DEF = 24;

   localparam logic [7:0]  TRIM_MAX_RESET = 8'd31;
   localparam logic [23:0] TARGET_RESET   = 24'd1000000;
   localparam logic [31:0] HIGH_SENTINEL  = 32'd2000000;

   // request codes
   localparam logic FUNC_START   = 1'b0;
   localparam logic FUNC_MEASURE = 1'b1;

   // register indexes
   localparam logic CSR_TRIM_MAX = 1'b0;
   localparam logic CSR_TARGET   = 1'b1;

   typedef struct packed {
      logic        func;
      logic [7:0]  start_trim;
      logic [23:0] micros_per_second;
   } req_type;

   typedef struct packed {
      logic [7:0] trim_value;
      logic       trim_changed;
      logic       done_res;
      logic       failed;
   } rsp_type;

   typedef struct packed {
      logic running;
      logic seen_high;
      logic seen_low;
   } flags_type;

endpackage

>>> src/ctc_csr.sv
// Configuration registers: trim limit and target count.
module ctc_csr
   import ctc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic        csr_index,
   input  logic [23:0] csr_data,
   output logic [7:0]  trim_max,
   output logic [23:0] target_micros
);

   logic [7:0]  trim_max_ff;
   logic [23:0] target_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         trim_max_ff <= TRIM_MAX_RESET;
         target_ff   <= TARGET_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_TRIM_MAX: trim_max_ff <= csr_data[7:0];
            CSR_TARGET:   target_ff   <= csr_data;
            default:      ;
         endcase
      end
   end

   assign trim_max      = trim_max_ff;
   assign target_micros = target_ff;

endmodule

>>> src/ctc_step.sv
// One search step: next search state and the response for one request.
module ctc_step
   import ctc_pkg::*;
#(
   parameter int TRIM_WIDTH    = TRIM_WIDTH_DEF,
   parameter int READING_WIDTH = READING_WIDTH_DEF
) (
   input  req_type                   req,
   input  logic [7:0]                trim_max,
   input  logic [23:0]               target_micros,
   input  flags_type                 flags,
   input  logic [TRIM_WIDTH-1:0]     cur_trim,
   input  logic [TRIM_WIDTH-1:0]     origin_trim,
   input  logic [TRIM_WIDTH-1:0]     low_trim,
   input  logic [TRIM_WIDTH-1:0]     high_trim,
   input  logic [READING_WIDTH-1:0]  low_reading,
   input  logic [READING_WIDTH-1:0]  high_reading,
   output flags_type                 flags_in,
   output logic [TRIM_WIDTH-1:0]     cur_trim_in,
   output logic [TRIM_WIDTH-1:0]     origin_trim_in,
   output logic [TRIM_WIDTH-1:0]     low_trim_in,
   output logic [TRIM_WIDTH-1:0]     high_trim_in,
   output logic [READING_WIDTH-1:0]  low_reading_in,
   output logic [READING_WIDTH-1:0]  high_reading_in,
   output rsp_type                   rsp
);

   localparam int CmpWidth = (READING_WIDTH > 24) ? READING_WIDTH : 24;
   localparam logic [TRIM_WIDTH-1:0] TrimMask = {TRIM_WIDTH{1'b1}};

   logic [TRIM_WIDTH-1:0]    start;
   logic [31:0]              reading_wide;
   logic [READING_WIDTH-1:0] reading;
   logic [TRIM_WIDTH-1:0]    limit;
   logic                     low_side;
   logic                     stop;
   logic [TRIM_WIDTH-1:0]    stepped;

   assign start        = req.start_trim[TRIM_WIDTH-1:0];
   assign reading_wide = {8'd0, req.micros_per_second};
   assign reading      = reading_wide[READING_WIDTH-1:0];
   assign low_side     = CmpWidth'(reading) <= CmpWidth'(target_micros);

   // saturate the limit to the largest code the trim holds
   always_comb begin
      if (|(trim_max >> TRIM_WIDTH)) limit = TrimMask;
      else                           limit = trim_max[TRIM_WIDTH-1:0];
   end

   always_comb begin
      flags_in        = flags;
      cur_trim_in     = cur_trim;
      origin_trim_in  = origin_trim;
      low_trim_in     = low_trim;
      high_trim_in    = high_trim;
      low_reading_in  = low_reading;
      high_reading_in = high_reading;
      stepped         = cur_trim;
      stop            = 1'b0;
      rsp             = '0;
      rsp.trim_value  = 8'(cur_trim);

      if (req.func == FUNC_START) begin
         cur_trim_in        = start;
         origin_trim_in     = start;
         low_trim_in        = '0;
         high_trim_in       = '0;
         low_reading_in     = '0;
         high_reading_in    = HIGH_SENTINEL[READING_WIDTH-1:0];
         flags_in.running   = 1'b1;
         flags_in.seen_low  = 1'b0;
         flags_in.seen_high = 1'b0;
         rsp.trim_value     = 8'(start);
      end else if (flags.running) begin
         if (low_side) begin
            if (reading > low_reading) begin
               low_reading_in    = reading;
               low_trim_in       = cur_trim;
               flags_in.seen_low = 1'b1;
            end
            if (!flags.seen_high) begin
               if (cur_trim < limit) stepped = TRIM_WIDTH'(cur_trim + 1'b1);
               else                  stop    = 1'b1;
            end
         end else begin
            if (reading < high_reading) begin
               high_reading_in    = reading;
               high_trim_in       = cur_trim;
               flags_in.seen_high = 1'b1;
            end
            if (!flags.seen_low) begin
               if (cur_trim == '0) stop    = 1'b1;
               else                stepped = TRIM_WIDTH'(cur_trim - 1'b1);
            end
         end

         if (stepped == origin_trim || (flags_in.seen_low && flags_in.seen_high)) begin
            stop = 1'b1;
         end

         cur_trim_in = stepped;
         if (stop) begin
            // settle on the closest high code, then the closest low one, else fail back to the origin
            priority if (flags_in.seen_high) cur_trim_in = high_trim_in;
            else if (flags_in.seen_low)      cur_trim_in = low_trim_in;
            else begin
               cur_trim_in = origin_trim;
               rsp.failed  = 1'b1;
            end
            flags_in.running = 1'b0;
         end

         rsp.trim_value   = 8'(cur_trim_in);
         rsp.trim_changed = cur_trim_in != cur_trim;
         rsp.done_res     = stop;
      end
   end

endmodule

>>> src/clock_trim_calibrator.sv
// Top level of the clock trim calibrator: handshakes, search state, result register.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_ready   req_payload (req_type)
//   rsp      out        rsp_valid / rsp_ready   rsp_payload (rsp_type)
//   csr      in         csr_valid / csr_ready   csr_index, csr_data
//
// A request is captured in the input register and worked once the result
// register is free or draining, which loads its response into the result
// register; one request per cycle while the response output is not stalled.
// The input register frees itself whenever the result register loads, so
// requests keep flowing while a response waits, until both are full.
// Reset clears the search state, sets the high reading to 2000000 and loads trim_max 31 and target 1000000.
// csr_ready is always high; writes take effect in the next cycle.
module clock_trim_calibrator
   import ctc_pkg::*;
#(
   parameter int TRIM_WIDTH    = TRIM_WIDTH_DEF,
   parameter int READING_WIDTH = READING_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_payload,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [23:0] csr_data
);

   logic [7:0]  trim_max;
   logic [23:0] target_micros;

   logic    req_valid_ff;
   req_type req_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   logic    advance;

   flags_type                flags_ff, flags_in;
   logic [TRIM_WIDTH-1:0]    cur_trim_ff, cur_trim_in;
   logic [TRIM_WIDTH-1:0]    origin_trim_ff, origin_trim_in;
   logic [TRIM_WIDTH-1:0]    low_trim_ff, low_trim_in;
   logic [TRIM_WIDTH-1:0]    high_trim_ff, high_trim_in;
   logic [READING_WIDTH-1:0] low_reading_ff, low_reading_in;
   logic [READING_WIDTH-1:0] high_reading_ff, high_reading_in;
   rsp_type                  rsp_in;

   ctc_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .trim_max      (trim_max),
      .target_micros (target_micros)
   );

   ctc_step #(
      .TRIM_WIDTH    (TRIM_WIDTH),
      .READING_WIDTH (READING_WIDTH)
   ) u_step (
      .req             (req_ff),
      .trim_max        (trim_max),
      .target_micros   (target_micros),
      .flags           (flags_ff),
      .cur_trim        (cur_trim_ff),
      .origin_trim     (origin_trim_ff),
      .low_trim        (low_trim_ff),
      .high_trim       (high_trim_ff),
      .low_reading     (low_reading_ff),
      .high_reading    (high_reading_ff),
      .flags_in        (flags_in),
      .cur_trim_in     (cur_trim_in),
      .origin_trim_in  (origin_trim_in),
      .low_trim_in     (low_trim_in),
      .high_trim_in    (high_trim_in),
      .low_reading_in  (low_reading_in),
      .high_reading_in (high_reading_in),
      .rsp             (rsp_in)
   );

   // work the held request when the result register is free or draining
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff        <= '0;
         cur_trim_ff     <= '0;
         origin_trim_ff  <= '0;
         low_trim_ff     <= '0;
         high_trim_ff    <= '0;
         low_reading_ff  <= '0;
         high_reading_ff <= HIGH_SENTINEL[READING_WIDTH-1:0];
      end else if (advance) begin
         flags_ff        <= flags_in;
         cur_trim_ff     <= cur_trim_in;
         origin_trim_ff  <= origin_trim_in;
         low_trim_ff     <= low_trim_in;
         high_trim_ff    <= high_trim_in;
         low_reading_ff  <= low_reading_in;
         high_reading_ff <= high_reading_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> src/ctc_checker.sv
// Port-level checker for the clock trim calibrator, bound to the top level.
`include "assert_macros.svh"

module ctc_checker
   import ctc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   `CTC_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> (!rsp_valid && req_ready), "not empty after reset")

   `CTC_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)), "stalled response changed")

   `CTC_ASSERT(a_fail_done, clock, reset, (rsp_valid && rsp_payload.failed) |-> rsp_payload.done_res, "failure without done")

   `CTC_ASSERT(a_block_full, clock, reset, !req_ready |-> (rsp_valid && !rsp_ready), "request blocked with free output")

endmodule

bind clock_trim_calibrator ctc_checker u_checker (.*);
